// ===== hw/rtl/pipt_pkg.sv =====
// Shared constants, types and command struct for the point-in-polygon tester.
package pipt_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int COORD_BITS   = 12;
	localparam int COUNT_W      = 4;
	localparam int VIDX_W       = 3;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	// signed differences plus headroom for d+1
	localparam int DIFF_W       = COORD_BITS + 2;
	localparam int MUL_W        = 2 * DIFF_W;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREV,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_DONE
	} pipt_state_t;

	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic [IDX_W-1:0] rd_addr;
		logic             prev_load;
		logic             edge_a;
		logic             edge_b;
		logic             out_load;
	} pipt_cmd_t;

endpackage

// ===== hw/rtl/pipt_ctrl.sv =====
// Controller: sequences the edge walk, holds vertex count and result valid.
module pipt_ctrl
	import pipt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pipt_cmd_t           dp_cmd
);

	pipt_state_t        state_q, state_nxt;
	logic [IDX_W-1:0]   i_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	logic [CNT_W-1:0]   n_w;
	logic               last_w;
	logic               out_free;
	logic               take_w;

	assign n_w = (int'(count_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(count_q);
	assign last_w = (CNT_W'(i_q) + CNT_W'(1)) == n_w;
	assign out_free = !out_valid_q || out_ready;
	assign take_w = (state_q == ST_IDLE) && in_valid;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid)
				count_q <= cfg_data;
			if (state_q == ST_PREV)
				i_q <= '0;
			else if (state_q == ST_EDGE_B)
				i_q <= i_q + IDX_W'(1);
			if (dp_cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take_w && cmd == CMD_TEST)
					state_nxt = (n_w == '0) ? ST_DONE : ST_PREV;
			end
			ST_PREV:   state_nxt = ST_EDGE_A;
			ST_EDGE_A: state_nxt = ST_EDGE_B;
			ST_EDGE_B: state_nxt = last_w ? ST_DONE : ST_EDGE_A;
			ST_DONE: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = (state_q == ST_IDLE);
		dp_cmd.wr_en     = take_w && (cmd == CMD_LOAD);
		dp_cmd.start     = take_w && (cmd == CMD_TEST);
		dp_cmd.prev_load = (state_q == ST_PREV) || (state_q == ST_EDGE_A);
		dp_cmd.edge_a    = (state_q == ST_EDGE_A);
		dp_cmd.edge_b    = (state_q == ST_EDGE_B);
		dp_cmd.out_load  = (state_q == ST_DONE) && out_free;
		unique case (state_q)
			ST_IDLE:   dp_cmd.rd_addr = IDX_W'(n_w - CNT_W'(1));
			ST_PREV:   dp_cmd.rd_addr = '0;
			ST_EDGE_B: dp_cmd.rd_addr = i_q + IDX_W'(1);
			default:   dp_cmd.rd_addr = i_q;
		endcase
	end

endmodule

// ===== hw/rtl/pipt_dp.sv =====
// Datapath: vertex memory, two-stage crossing test per edge, parity flag.
module pipt_dp
	import pipt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  pipt_cmd_t             dp_cmd,
	input  logic [VIDX_W-1:0]     vertex_index,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	output logic                  inside_res
);

	localparam logic signed [DIFF_W-1:0] ONE_S = DIFF_W'(1);

	logic [COORD_BITS-1:0] x_mem [MAX_VERTICES];
	logic [COORD_BITS-1:0] y_mem [MAX_VERTICES];
	logic [COORD_BITS-1:0] rd_x_q, rd_y_q;
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] px_q, py_q;

	logic signed [DIFF_W-1:0] xi_s, yi_s, xj_s, yj_s, px_s, py_s;
	logic signed [DIFF_W-1:0] dy, dx, ey, mul_a, den_a;
	logic signed [MUL_W-1:0]  num_a;
	logic                     straddle_a;

	logic signed [MUL_W-1:0]  num_s1;
	logic signed [DIFF_W-1:0] den_s1, d_s1;
	logic                     straddle_s1;

	logic signed [DIFF_W-1:0] mpy_b;
	logic signed [MUL_W-1:0]  prod_b;
	logic                     cross_b;
	logic                     flag_q, res_q;

	always_ff @(posedge clk) begin
		if (dp_cmd.wr_en && int'(vertex_index) < MAX_VERTICES) begin
			x_mem[IDX_W'(vertex_index)] <= vertex_x;
			y_mem[IDX_W'(vertex_index)] <= vertex_y;
		end
		rd_x_q <= x_mem[dp_cmd.rd_addr];
		rd_y_q <= y_mem[dp_cmd.rd_addr];
	end

	// stage A: straddle check, numerator product, sign normalized so den > 0
	always_comb begin
		xi_s = signed'(DIFF_W'(rd_x_q));
		yi_s = signed'(DIFF_W'(rd_y_q));
		xj_s = signed'(DIFF_W'(prev_x_q));
		yj_s = signed'(DIFF_W'(prev_y_q));
		px_s = signed'(DIFF_W'(px_q));
		py_s = signed'(DIFF_W'(py_q));
		straddle_a = (yi_s > py_s) != (yj_s > py_s);
		dy    = yj_s - yi_s;
		dx    = xj_s - xi_s;
		ey    = py_s - yi_s;
		mul_a = dy[DIFF_W-1] ? -dx : dx;
		den_a = dy[DIFF_W-1] ? -dy : dy;
		num_a = MUL_W'(mul_a) * MUL_W'(ey);
	end

	// stage B: px - xi < trunc(num/den) without dividing
	always_comb begin
		mpy_b   = num_s1[MUL_W-1] ? d_s1 : d_s1 + ONE_S;
		prod_b  = MUL_W'(mpy_b) * MUL_W'(den_s1);
		cross_b = num_s1[MUL_W-1] ? (num_s1 > prod_b) : (num_s1 >= prod_b);
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			px_q <= point_x;
			py_q <= point_y;
		end
		if (dp_cmd.prev_load) begin
			prev_x_q <= rd_x_q;
			prev_y_q <= rd_y_q;
		end
		if (dp_cmd.edge_a) begin
			num_s1 <= num_a;
			den_s1 <= den_a;
			d_s1   <= px_s - xi_s;
		end
		if (dp_cmd.out_load)
			res_q <= flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= 1'b0;
			straddle_s1 <= 1'b0;
		end else begin
			if (dp_cmd.edge_a)
				straddle_s1 <= straddle_a;
			if (dp_cmd.start)
				flag_q <= 1'b0;
			else if (dp_cmd.edge_b && straddle_s1 && cross_b)
				flag_q <= !flag_q;
		end
	end

	assign inside_res = res_q;

endmodule

// ===== hw/rtl/point_in_polygon_test.sv =====
// Top level: even-odd point-in-polygon tester with vertex table.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | cmd, vertex_index, vertex_x/y, point_x/y
//  cfg     | cfg_valid/cfg_ready  | cfg_data (vertex count)
//  out     | out_valid/out_ready  | inside_res
//
// A load word produces nothing and leaves the input ready.
// A test word on n vertices holds the input until the walk ends: on accept the last
// vertex is fetched, then vertex 0, each edge goes through multiply stages A and B,
// and DONE loads the result; with n = 0 the walk goes straight to DONE.
// The result sits in an output register; loads still go while it waits, but the next
// test holds in its last state, and the input with it, until the register frees.
// Reset clears control state; the table is not cleared.
module point_in_polygon_test
	import pipt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [VIDX_W-1:0]     vertex_index,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_W-1:0]    cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  inside_res
);

	pipt_cmd_t dp_cmd;

	pipt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd)
	);

	pipt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.inside_res   (inside_res)
	);

	// a test word always leaves idle
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_TEST) |=> !in_ready)
		else $error("test word did not start a walk");

	// a load word leaves the input ready
	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_LOAD) |=> in_ready)
		else $error("load word stalled the input");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// walk steps never overlap the write path
	a_walk_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.edge_a || dp_cmd.edge_b) |-> (!dp_cmd.wr_en && !in_ready))
		else $error("edge step while input open");

endmodule

// ===== dv/tb_point_in_polygon_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the even-odd point-in-polygon tester.
module tb_point_in_polygon_test;
	import pipt_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 12;
	// longest walk plus margin
	localparam int SETTLE_CYCLES = 2 * MAX_VERTICES + 6;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int ITEM_TARGET   = 700;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  cmd          = CMD_LOAD;
	logic [VIDX_W-1:0]     vertex_index = '0;
	logic [COORD_BITS-1:0] vertex_x     = '0;
	logic [COORD_BITS-1:0] vertex_y     = '0;
	logic [COORD_BITS-1:0] point_x      = '0;
	logic [COORD_BITS-1:0] point_y      = '0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data     = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic                  inside_res;

	// shadow of the vertex table and count, updated as words are accepted
	logic [COORD_BITS-1:0] poly_x [MAX_VERTICES];
	logic [COORD_BITS-1:0] poly_y [MAX_VERTICES];
	int unsigned           poly_count = 0;
	logic                  inside_exp_q [$];

	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          items_sent     = 0;
	bit          tx_bursty      = 1'b0;
	int          burst_left     = 0;
	int          rx_stall_pct   = 0;
	int          hold_req       = 0;
	int          hold_seen      = 0;
	int          hold_left      = 0;

	point_in_polygon_test dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.inside_res   (inside_res)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic pnpoly_inside(logic [COORD_BITS-1:0] px_in,
		logic [COORD_BITS-1:0] py_in);
		int     n;
		int     i;
		int     j;
		longint xi, yi, xj, yj, px, py;
		logic   in_poly;
		in_poly = 1'b0;
		n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : poly_count;
		px = longint'(px_in);
		py = longint'(py_in);
		j = n - 1;
		for (i = 0; i < n; i++) begin
			xi = longint'(poly_x[IDX_W'(i)]);
			yi = longint'(poly_y[IDX_W'(i)]);
			xj = longint'(poly_x[IDX_W'(j)]);
			yj = longint'(poly_y[IDX_W'(j)]);
			// straddle test keeps the divisor nonzero; signed divide truncates to zero
			if ((yi > py) != (yj > py)) begin
				if (px < (xj - xi) * (py - yi) / (yj - yi) + xi)
					in_poly = ~in_poly;
			end
			j = i;
		end
		return in_poly;
	endfunction

	function automatic int clamp_coord(int v);
		if (v < 0)
			return 0;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	// Entered and left at a falling edge; in_valid is left high for a following word unless a burst gap drops it.
	task automatic send_word(input logic c, input logic [VIDX_W-1:0] idx,
		input logic [COORD_BITS-1:0] vx, input logic [COORD_BITS-1:0] vy,
		input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
		int gap;
		in_valid     <= 1'b1;
		cmd          <= c;
		vertex_index <= idx;
		vertex_x     <= vx;
		vertex_y     <= vy;
		point_x      <= px;
		point_y      <= py;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (c == CMD_LOAD) begin
			poly_x[idx] = vx;
			poly_y[idx] = vy;
		end else begin
			inside_exp_q.push_back(pnpoly_inside(px, py));
		end
		@(negedge clk);
		if (tx_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic load_vertex(input int unsigned idx, input int vx, input int vy);
		send_word(CMD_LOAD, VIDX_W'(idx), COORD_BITS'(vx), COORD_BITS'(vy),
			COORD_BITS'($urandom), COORD_BITS'($urandom));
	endtask

	task automatic test_point(input int px, input int py);
		send_word(CMD_TEST, VIDX_W'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom), COORD_BITS'(px), COORD_BITS'(py));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (inside_exp_q.size() != 0);
	endtask

	task automatic write_vertex_count(input int unsigned count);
		drain_results();
		// a load may still be in flight after the last result
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= COUNT_W'(count);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		poly_count = count;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_zero_vertices();
		// count is zero out of reset; no table entry is used
		test_point(0, 0);
		test_point(COORD_MAX, COORD_MAX);
	endtask

	task automatic test_square();
		load_vertex(0, 1024, 1024);
		load_vertex(1, 3072, 1024);
		load_vertex(2, 3072, 3072);
		load_vertex(3, 1024, 3072);
		write_vertex_count(4);
		test_point(2048, 2048);
		test_point(1023, 2048);
		test_point(1024, 2048);
		test_point(2048, 1024);
		test_point(3072, 3072);
	endtask

	task automatic test_octagon_full_table();
		load_vertex(0, 1024, 0);
		load_vertex(1, 3071, 0);
		load_vertex(2, COORD_MAX, 1024);
		load_vertex(3, COORD_MAX, 3071);
		load_vertex(4, 3071, COORD_MAX);
		load_vertex(5, 1024, COORD_MAX);
		load_vertex(6, 0, 3071);
		load_vertex(7, 0, 1024);
		write_vertex_count(MAX_VERTICES);
		test_point(2048, 2048);
		test_point(0, 0);
		test_point(COORD_MAX, 2048);
	endtask

	task automatic test_count_extremes();
		// single vertex and two-vertex degenerate shapes
		write_vertex_count(1);
		test_point(1000, 0);
		write_vertex_count(2);
		test_point(1500, 0);
		// counts above the table size act as a full table
		write_vertex_count(12);
		test_point(2048, 2048);
		write_vertex_count(15);
		test_point(100, 2048);
		write_vertex_count(0);
		test_point(2048, 2048);
	endtask

	task automatic test_output_backpressure();
		tx_bursty = 1'b0;
		rx_stall_pct <= 0;
		write_vertex_count(MAX_VERTICES);
		hold_req <= hold_req + 1;
		repeat (24)
			test_point($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
		drain_results();
	endtask

	task automatic test_random_polygons();
		int n, n_eff, shape, npts, sel, k, t, seg, f;
		int x0, y0, x1, y1, w, h, per, cx, cy, vx, vy, px, py;
		while (items_sent < ITEM_TARGET) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				n = $urandom_range(0, 2);
			else if (sel == 1)
				n = $urandom_range(MAX_VERTICES + 1, 15);
			else
				n = $urandom_range(3, MAX_VERTICES);
			n_eff = (n > MAX_VERTICES) ? MAX_VERTICES : n;
			shape = $urandom_range(0, 3);
			tx_bursty = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: rx_stall_pct <= 0;
				1: rx_stall_pct <= 20;
				2: rx_stall_pct <= 50;
				default: rx_stall_pct <= 80;
			endcase
			x0 = $urandom_range(0, COORD_MAX - 300);
			x1 = $urandom_range(x0 + 16, COORD_MAX);
			y0 = $urandom_range(0, COORD_MAX - 300);
			y1 = $urandom_range(y0 + 16, COORD_MAX);
			w = x1 - x0;
			h = y1 - y0;
			per = 2 * (w + h);
			cx = (x0 + x1) / 2;
			cy = (y0 + y1) / 2;
			// vertices in order around the box perimeter give a convex shape
			for (k = 0; k < n_eff; k++) begin
				seg = per / n_eff;
				t = k * seg + $urandom_range(0, seg - 1);
				if (t < w) begin
					vx = x0 + t;
					vy = y0;
				end else if (t < w + h) begin
					vx = x1;
					vy = y0 + (t - w);
				end else if (t < 2 * w + h) begin
					vx = x1 - (t - w - h);
					vy = y1;
				end else begin
					vx = x0;
					vy = y1 - (t - 2 * w - h);
				end
				if (shape == 1) begin
					// pull toward the center: star shaped, concave
					f = $urandom_range(4, 16);
					vx = cx + (vx - cx) * f / 16;
					vy = cy + (vy - cy) * f / 16;
				end else if (shape == 2) begin
					vx = $urandom_range(0, COORD_MAX);
					vy = $urandom_range(0, COORD_MAX);
				end
				load_vertex(k, vx, vy);
			end
			write_vertex_count(n);
			npts = $urandom_range(8, 24);
			repeat (npts) begin
				sel = $urandom_range(0, 19);
				px = x0 - 64 + $urandom_range(0, w + 128);
				py = y0 - 64 + $urandom_range(0, h + 128);
				if (sel == 0) begin
					load_vertex($urandom_range(0, MAX_VERTICES - 1),
						$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
				end else begin
					if (sel <= 2 && n_eff > 0) begin
						k = $urandom_range(0, n_eff - 1);
						px = int'(poly_x[IDX_W'(k)]);
						py = int'(poly_y[IDX_W'(k)]);
					end else if (sel <= 4 && n_eff > 0) begin
						py = int'(poly_y[IDX_W'($urandom_range(0, n_eff - 1))]);
					end else if (sel == 5) begin
						px = $urandom_range(0, 1) * COORD_MAX;
						py = $urandom_range(0, 1) * COORD_MAX;
					end else if (sel <= 7) begin
						px = $urandom_range(0, COORD_MAX);
						py = $urandom_range(0, COORD_MAX);
					end
					test_point(clamp_coord(px), clamp_coord(py));
				end
			end
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (inside_exp_q.size() == 0) begin
				$display("%0t: unexpected result word: expected none, actual inside_res=%0b",
					$time, inside_res);
				mismatch_count++;
			end else begin
				if (inside_res !== inside_exp_q[0]) begin
					$display("%0t: inside_res mismatch: expected %0b, actual %0b",
						$time, inside_exp_q[0], inside_res);
					mismatch_count++;
				end
				void'(inside_exp_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_point_in_polygon_test: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_zero_vertices();
		test_square();
		test_octagon_full_table();
		test_count_extremes();
		test_output_backpressure();
		test_random_polygons();
		rx_stall_pct <= 0;
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && inside_exp_q.size() == 0)
			$display("tb_point_in_polygon_test: PASS");
		else
			$display("tb_point_in_polygon_test: FAIL");
		$finish;
	end

endmodule
